/* design/assert_macros.svh */
// assertion macros included by the formatter module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* design/sdmf_pkg.sv */
// types and constants of the segment display mode formatter
package sdmf_pkg;

   // digit codes
   localparam logic [5:0] CODE_BLANK = 6'd16;
   localparam logic [5:0] CODE_DASH  = 6'd17;
   localparam logic [5:0] CODE_C     = 6'd12;
   localparam logic [5:0] CODE_UNIT  = 6'd30;

   // key press codes
   localparam logic [7:0] KEY_BRIGHT = 8'd4;
   localparam logic [7:0] KEY_MODE   = 8'd5;

   // brightness range
   localparam logic [3:0] BRIGHT_MAX   = 4'd9;
   localparam logic [3:0] BRIGHT_RESET = 4'd6;

   // display views
   typedef enum logic [2:0] {
      MODE_TIME   = 3'd0,
      MODE_TEMP   = 3'd1,
      MODE_ANALOG = 3'd2,
      MODE_DIST   = 3'd3,
      MODE_FREQ   = 3'd4,
      MODE_BRIGHT = 3'd5
   } mode_type;

   // decimal digits of a 16-bit value, d0 is the units digit
   typedef struct packed {
      logic [3:0] d4;
      logic [3:0] d3;
      logic [3:0] d2;
      logic [3:0] d1;
      logic [3:0] d0;
   } dec_type;

   // input word
   typedef struct packed {
      logic [7:0]  key_code;
      logic [7:0]  rtc_hours;
      logic [7:0]  rtc_minutes;
      logic [7:0]  rtc_seconds;
      logic [15:0] temp_hundredths;
      logic [15:0] analog_a_hundredths;
      logic [15:0] analog_b_hundredths;
      logic [7:0]  distance_cm;
      logic [15:0] frequency_hz;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [5:0] digit_0;
      logic [5:0] digit_1;
      logic [5:0] digit_2;
      logic [5:0] digit_3;
      logic [5:0] digit_4;
      logic [5:0] digit_5;
      logic [5:0] digit_6;
      logic [5:0] digit_7;
      logic [2:0] show_mode;
      logic [3:0] brightness;
   } rsp_word_type;

endpackage

/* design/segment_display_mode_formatter.sv */
// top level of the segment display mode formatter
//
// The req channel carries one word per display update: the raw key code and
// the current readings (BCD time, temperature, two analog values, distance,
// frequency). On acceptance the key press is detected against the previous
// key code; a press of key 4 steps the brightness 0..9 and a press of key 5
// steps the view 0..5, both wrapping. The rsp channel returns one word per
// req word: eight digit codes for the current view (0..15 glyph, 16 blank,
// 17 dash, 30 unit, +32 decimal point), the view and the brightness.
// An accepted word is held in the input register, is loaded into the result
// register once that is free, and is offered on rsp from then on.
// Throughput: one word per cycle while rsp_stall is low, set by the single
// input register stage and the result register; the digit split is three
// constant multiplies, a top digit compare and a subtract per lower digit.
// Reset clears the previous key, selects the time view, sets brightness 6
// and empties both stages. A result waiting under rsp_stall is held there;
// an empty input stage takes one more word, then req_stall rises.
module segment_display_mode_formatter
   import sdmf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

`include "assert_macros.svh"

   // reciprocal constants for division by 10, 100 and 1000
   localparam logic [31:0] RECIP_10   = 32'd52429;
   localparam logic [32:0] RECIP_100  = 33'd83887;
   localparam logic [32:0] RECIP_1000 = 33'd67109;

   logic [7:0]   prev_key_ff;
   logic [7:0]   prev_key_in;
   mode_type     mode_ff;
   mode_type     mode_in;
   logic [3:0]   bright_ff;
   logic [3:0]   bright_in;
   logic [7:0]   press;
   logic         req_accept;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;
   mode_type     s1_mode_ff;
   logic [3:0]   s1_bright_ff;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;
   logic         res_ready;

   logic [15:0]  op_a;
   dec_type      dec_a;
   dec_type      dec_b;

   // remainder of n by 10 from the quotient q, low four bits suffice
   function automatic logic [3:0] rem10(input logic [3:0] n, input logic [3:0] q);
      rem10 = n - {q[0], 3'b000} - {q[2:0], 1'b0};
   endfunction

   // split a 16-bit value into five decimal digits
   function automatic dec_type split5(input logic [15:0] v);
      logic [31:0] p1;
      logic [32:0] p2;
      logic [32:0] p3;
      logic [12:0] q1;
      logic [9:0]  q2;
      logic [6:0]  q3;
      logic [2:0]  q4;
      dec_type     r;
      p1 = {16'd0, v} * RECIP_10;
      p2 = {17'd0, v} * RECIP_100;
      p3 = {17'd0, v} * RECIP_1000;
      q1 = p1[31:19];
      q2 = p2[32:23];
      q3 = p3[32:26];
      if (v >= 16'd60000)      q4 = 3'd6;
      else if (v >= 16'd50000) q4 = 3'd5;
      else if (v >= 16'd40000) q4 = 3'd4;
      else if (v >= 16'd30000) q4 = 3'd3;
      else if (v >= 16'd20000) q4 = 3'd2;
      else if (v >= 16'd10000) q4 = 3'd1;
      else                     q4 = 3'd0;
      r.d0 = rem10(v[3:0], q1[3:0]);
      r.d1 = rem10(q1[3:0], q2[3:0]);
      r.d2 = rem10(q2[3:0], q3[3:0]);
      r.d3 = rem10(q3[3:0], {1'b0, q4});
      r.d4 = {1'b0, q4};
      return r;
   endfunction

   // plain digit code and digit code with point
   function automatic logic [5:0] glyph(input logic [3:0] d);
      glyph = {2'b00, d};
   endfunction

   function automatic logic [5:0] glyph_pt(input logic [3:0] d);
      glyph_pt = {2'b10, d};
   endfunction

   // handshake
   assign res_ready  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !res_ready;
   assign req_accept = req_valid && !req_stall;

   // key press detection and view / brightness stepping
   always_comb begin
      press       = req_word.key_code & (req_word.key_code ^ prev_key_ff);
      prev_key_in = prev_key_ff;
      mode_in     = mode_ff;
      bright_in   = bright_ff;
      if (req_accept) begin
         prev_key_in = req_word.key_code;
         if (press == KEY_BRIGHT) begin
            bright_in = (bright_ff == BRIGHT_MAX) ? 4'd0 : bright_ff + 4'd1;
         end
         if (press == KEY_MODE) begin
            mode_in = (mode_ff == MODE_BRIGHT) ? MODE_TIME : mode_type'(mode_ff + 3'd1);
         end
      end
   end

   // stage valid flags
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = s1_valid_ff;
         s1_valid_in  = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end
   end

   // value to split for the selected view
   always_comb begin
      case (s1_mode_ff)
         MODE_TEMP:   op_a = s1_word_ff.temp_hundredths;
         MODE_ANALOG: op_a = s1_word_ff.analog_a_hundredths;
         MODE_DIST:   op_a = {8'd0, s1_word_ff.distance_cm};
         default:     op_a = s1_word_ff.frequency_hz;
      endcase
      dec_a = split5(op_a);
      dec_b = split5(s1_word_ff.analog_b_hundredths);
   end

   // digit codes for the view
   always_comb begin
      rsp_in            = '0;
      rsp_in.show_mode  = s1_mode_ff;
      rsp_in.brightness = s1_bright_ff;
      rsp_in.digit_0    = CODE_BLANK;
      rsp_in.digit_1    = CODE_BLANK;
      rsp_in.digit_2    = CODE_BLANK;
      rsp_in.digit_3    = CODE_BLANK;
      rsp_in.digit_4    = CODE_BLANK;
      rsp_in.digit_5    = CODE_BLANK;
      rsp_in.digit_6    = CODE_BLANK;
      rsp_in.digit_7    = CODE_BLANK;
      unique case (s1_mode_ff)
         MODE_TIME: begin
            rsp_in.digit_0 = glyph(s1_word_ff.rtc_hours[7:4]);
            rsp_in.digit_1 = glyph(s1_word_ff.rtc_hours[3:0]);
            rsp_in.digit_2 = CODE_DASH;
            rsp_in.digit_3 = glyph(s1_word_ff.rtc_minutes[7:4]);
            rsp_in.digit_4 = glyph(s1_word_ff.rtc_minutes[3:0]);
            rsp_in.digit_5 = CODE_DASH;
            rsp_in.digit_6 = glyph(s1_word_ff.rtc_seconds[7:4]);
            rsp_in.digit_7 = glyph(s1_word_ff.rtc_seconds[3:0]);
         end
         MODE_TEMP: begin
            rsp_in.digit_0 = CODE_C;
            rsp_in.digit_4 = glyph(dec_a.d3);
            rsp_in.digit_5 = glyph_pt(dec_a.d2);
            rsp_in.digit_6 = glyph(dec_a.d1);
            rsp_in.digit_7 = glyph(dec_a.d0);
         end
         MODE_ANALOG: begin
            rsp_in.digit_0 = glyph_pt(dec_a.d2);
            rsp_in.digit_1 = glyph(dec_a.d1);
            rsp_in.digit_2 = glyph(dec_a.d0);
            rsp_in.digit_5 = glyph_pt(dec_b.d2);
            rsp_in.digit_6 = glyph(dec_b.d1);
            rsp_in.digit_7 = glyph(dec_b.d0);
         end
         MODE_DIST: begin
            rsp_in.digit_4 = glyph(dec_a.d1);
            rsp_in.digit_5 = glyph(dec_a.d0);
            rsp_in.digit_6 = CODE_C;
            rsp_in.digit_7 = CODE_UNIT;
         end
         MODE_FREQ: begin
            rsp_in.digit_3 = glyph(dec_a.d4);
            rsp_in.digit_4 = glyph(dec_a.d3);
            rsp_in.digit_5 = glyph(dec_a.d2);
            rsp_in.digit_6 = glyph(dec_a.d1);
            rsp_in.digit_7 = glyph(dec_a.d0);
         end
         MODE_BRIGHT: begin
            rsp_in.digit_6 = glyph(4'd0);
            rsp_in.digit_7 = glyph(s1_bright_ff);
         end
         default: begin
            rsp_in.digit_0 = CODE_BLANK;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff  <= 8'd0;
         mode_ff      <= MODE_TIME;
         bright_ff    <= BRIGHT_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_key_ff  <= prev_key_in;
         mode_ff      <= mode_in;
         bright_ff    <= bright_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_word_ff   <= req_word;
         s1_mode_ff   <= mode_in;
         s1_bright_ff <= bright_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (res_ready && s1_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // assertions
   `ASSERT_CLK(a_no_overrun, clock, reset,
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall,
      "word taken while both stages are held")
   `ASSERT_CLK(a_stage_moves, clock, reset,
      (s1_valid_ff && res_ready) |=> rsp_valid_ff,
      "input stage word not moved into result register")
   `ASSERT_CLK(a_bright_hold, clock, reset,
      (!reset && !req_accept) |=> $stable(bright_ff),
      "brightness changed without an accepted word")
   `ASSERT_CLK(a_mode_range, clock, reset,
      mode_ff != 3'd6 && mode_ff != 3'd7,
      "view code out of range")
   `ASSERT_ALWAYS(a_bright_range, clock,
      reset || bright_ff <= BRIGHT_MAX,
      "brightness out of range")

endmodule

/* tb/testbench.sv */
// self-checking testbench for the segment display mode formatter
`timescale 1ns / 100ps

module testbench;
   import sdmf_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 11;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 633;
   localparam int HOLD_AFTER   = 40;
   localparam int HOLD_CYCLES  = 60;
   localparam int TAIL_CYCLES  = 10;
   localparam logic [5:0] POINT_MARK = 6'd32;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // words waiting to be offered, and display words still owed by the block
   req_word_type pending_words[$];
   rsp_word_type display_expected[$];

   // shadow of the block's state
   logic [7:0] last_key = 8'd0;
   mode_type   view = MODE_TIME;
   logic [3:0] level = BRIGHT_RESET;
   logic [5:0] shown [8] = '{default: CODE_BLANK};

   int   send_idle_pct = 26;
   int   recv_idle_pct = 88;
   int   failures = 0;
   int   results_seen = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;
   logic [7:0] queued_key = 8'd0;
   rsp_word_type want;

   segment_display_mode_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // one decimal digit of a reading
   function automatic logic [5:0] dec_at(input int unsigned value, input int unsigned div);
      return 6'((value / div) % 10);
   endfunction

   // key press detection, then the digits of the current view
   task automatic predict_display(input req_word_type w);
      logic [7:0]   press;
      rsp_word_type r;
      begin
         press = w.key_code & (w.key_code ^ last_key);
         last_key = w.key_code;
         if (press == KEY_BRIGHT) begin
            level = (level == BRIGHT_MAX) ? 4'd0 : level + 4'd1;
         end
         if (press == KEY_MODE) begin
            view = (view == MODE_BRIGHT) ? MODE_TIME : mode_type'(view + 3'd1);
         end
         case (view)
            MODE_TIME: begin
               shown[0] = {2'b00, w.rtc_hours[7:4]};
               shown[1] = {2'b00, w.rtc_hours[3:0]};
               shown[2] = CODE_DASH;
               shown[3] = {2'b00, w.rtc_minutes[7:4]};
               shown[4] = {2'b00, w.rtc_minutes[3:0]};
               shown[5] = CODE_DASH;
               shown[6] = {2'b00, w.rtc_seconds[7:4]};
               shown[7] = {2'b00, w.rtc_seconds[3:0]};
            end
            MODE_TEMP: begin
               shown = '{default: CODE_BLANK};
               shown[0] = CODE_C;
               shown[4] = dec_at(w.temp_hundredths, 1000);
               shown[5] = dec_at(w.temp_hundredths, 100) + POINT_MARK;
               shown[6] = dec_at(w.temp_hundredths, 10);
               shown[7] = dec_at(w.temp_hundredths, 1);
            end
            MODE_ANALOG: begin
               shown = '{default: CODE_BLANK};
               shown[0] = dec_at(w.analog_a_hundredths, 100) + POINT_MARK;
               shown[1] = dec_at(w.analog_a_hundredths, 10);
               shown[2] = dec_at(w.analog_a_hundredths, 1);
               shown[5] = dec_at(w.analog_b_hundredths, 100) + POINT_MARK;
               shown[6] = dec_at(w.analog_b_hundredths, 10);
               shown[7] = dec_at(w.analog_b_hundredths, 1);
            end
            MODE_DIST: begin
               shown = '{default: CODE_BLANK};
               shown[4] = dec_at(w.distance_cm, 10);
               shown[5] = dec_at(w.distance_cm, 1);
               shown[6] = CODE_C;
               shown[7] = CODE_UNIT;
            end
            MODE_FREQ: begin
               shown = '{default: CODE_BLANK};
               shown[3] = dec_at(w.frequency_hz, 10000);
               shown[4] = dec_at(w.frequency_hz, 1000);
               shown[5] = dec_at(w.frequency_hz, 100);
               shown[6] = dec_at(w.frequency_hz, 10);
               shown[7] = dec_at(w.frequency_hz, 1);
            end
            MODE_BRIGHT: begin
               shown = '{default: CODE_BLANK};
               shown[6] = dec_at(level, 10);
               shown[7] = dec_at(level, 1);
            end
            default: begin
               // unused view codes keep the old digits
            end
         endcase
         r.digit_0    = shown[0];
         r.digit_1    = shown[1];
         r.digit_2    = shown[2];
         r.digit_3    = shown[3];
         r.digit_4    = shown[4];
         r.digit_5    = shown[5];
         r.digit_6    = shown[6];
         r.digit_7    = shown[7];
         r.show_mode  = view;
         r.brightness = level;
         display_expected.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s expected %0d got %0d", name, exp_val, got_val);
         failures++;
      end
   endtask

   task automatic queue_word(input logic [7:0] key, input logic [7:0] hrs,
                             input logic [7:0] mins, input logic [7:0] secs,
                             input logic [15:0] temp, input logic [15:0] ana,
                             input logic [15:0] anb, input logic [7:0] dst,
                             input logic [15:0] freq);
      req_word_type w;
      begin
         w = '{key, hrs, mins, secs, temp, ana, anb, dst, freq};
         queued_key = key;
         pending_words.push_back(w);
      end
   endtask

   // byte readings: extremes, valid bcd, or anything
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hff;
         2, 3: return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
         default: return 8'($urandom);
      endcase
   endfunction

   // 16-bit readings: extremes, small values, or anything
   function automatic logic [15:0] pick_half();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(0, 9999));
         3: return 16'($urandom_range(0, 999));
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly clean presses and releases, some held keys and key noise
   task automatic queue_random_word();
      int         pick;
      logic [7:0] key;
      begin
         pick = $urandom_range(0, 99);
         if (pick < 30) key = 8'd0;
         else if (pick < 50) key = KEY_MODE;
         else if (pick < 65) key = KEY_BRIGHT;
         else if (pick < 75) key = queued_key;
         else if (pick < 85) key = queued_key | 8'($urandom_range(1, 7));
         else key = 8'($urandom);
         queue_word(key, pick_byte(), pick_byte(), pick_byte(), pick_half(), pick_half(),
                    pick_half(), pick_byte(), pick_half());
      end
   endtask

   task automatic wait_for_sender();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // driver: hold a stalled word, otherwise offer the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_display(req_word);
            void'(pending_words.pop_front());
         end
         if (!(req_valid && req_stall)) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word  <= pending_words[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted word, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (display_expected.size() == 0) begin
               $error("result word with none expected");
               failures++;
            end else begin
               want = display_expected.pop_front();
               check_field("digit_0", want.digit_0, rsp_word.digit_0);
               check_field("digit_1", want.digit_1, rsp_word.digit_1);
               check_field("digit_2", want.digit_2, rsp_word.digit_2);
               check_field("digit_3", want.digit_3, rsp_word.digit_3);
               check_field("digit_4", want.digit_4, rsp_word.digit_4);
               check_field("digit_5", want.digit_5, rsp_word.digit_5);
               check_field("digit_6", want.digit_6, rsp_word.digit_6);
               check_field("digit_7", want.digit_7, rsp_word.digit_7);
               check_field("show_mode", want.show_mode, rsp_word.show_mode);
               check_field("brightness", want.brightness, rsp_word.brightness);
            end
            results_seen++;
            if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         // one long hold-off so the block backs up into its input
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus sequence
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // time view at the extremes and with a real clock reading
      queue_word(8'd0, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 8'hff, 16'hffff);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000);
      queue_word(8'd0, 8'h23, 8'h59, 8'h58, 16'd2500, 16'd330, 16'd500, 8'd42, 16'd1000);
      // brightness steps, a held key, and the wrap past nine
      queue_word(KEY_BRIGHT, 8'h12, 8'h34, 8'h56, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_BRIGHT, 8'h9a, 8'hbc, 8'hde, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h01, 8'h02, 8'h03, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_BRIGHT, 8'h10, 8'h20, 8'h30, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h11, 8'h22, 8'h33, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_BRIGHT, 8'h44, 8'h55, 8'h66, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h77, 8'h88, 8'h99, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_BRIGHT, 8'hf0, 8'h0f, 8'ha5, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      // stray bits, and a mode key masked by a bit already held
      queue_word(8'h84, 8'h5a, 8'h3c, 8'hc3, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_MODE, 8'h01, 8'h01, 8'h01, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h02, 8'h02, 8'h02, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      // temperature with a hidden ten-thousands digit
      queue_word(KEY_MODE, 8'h00, 8'h00, 8'h00, 16'd65535, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd7, 8'h00, 8'h00, 8'h00, 16'd9999, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd2, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      // combined key code whose new bits form a mode press
      queue_word(8'd7, 8'h00, 8'h00, 8'h00, 16'd0, 16'd65535, 16'd999, 8'd0, 16'd0);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd100, 8'd0, 16'd0);
      // distance, frequency and brightness views
      queue_word(KEY_MODE, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd255, 16'd0);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd99, 16'd0);
      queue_word(KEY_MODE, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd65535);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_MODE, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(KEY_BRIGHT, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      queue_word(8'd0, 8'h00, 8'h00, 8'h00, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      // back round to the time view
      queue_word(KEY_MODE, 8'h12, 8'h00, 8'h59, 16'd0, 16'd0, 16'd0, 8'd0, 16'd0);
      wait_for_sender();

      // random words: slow receiver, then slow sender, then full rate
      repeat (RANDOM_WORDS) queue_random_word();
      wait_for_sender();
      send_idle_pct = 88;
      recv_idle_pct = 26;
      repeat (RANDOM_WORDS) queue_random_word();
      wait_for_sender();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (RANDOM_WORDS) queue_random_word();
      wait_for_sender();

      // drain, then let any stray word show up
      while (display_expected.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/sdmf_pkg.sv
design/segment_display_mode_formatter.sv
tb/testbench.sv
